### rtl/core/tdcf_pkg.sv
// ----------------------------------------------------------------------------
// tdcf_pkg
// Shared codes, widths and types of the tracked drive command block
// ----------------------------------------------------------------------------
package tdcf_pkg;

   localparam int TIMEOUT_BITS = 16;
   localparam int MS_BITS      = 17;
   localparam int BURST_BITS   = 15;
   localparam int AMOUNT_BITS  = 32;

   localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET = 16'd500;
   localparam logic [BURST_BITS-1:0]   BURST_MAX     = 15'd32767;
   localparam logic [MS_BITS-1:0]      MS_MAX        = 17'h1FFFF;

   // request operations
   localparam logic [1:0] OP_COMMAND      = 2'd0;
   localparam logic [1:0] OP_TICK         = 2'd1;
   localparam logic [1:0] OP_UPDATE_START = 2'd2;
   localparam logic [1:0] OP_UPDATE_END   = 2'd3;

   // command targets
   localparam logic [2:0] TGT_TRACK  = 3'd0;
   localparam logic [2:0] TGT_TURRET = 3'd1;
   localparam logic [2:0] TGT_TILT   = 3'd2;
   localparam logic [2:0] TGT_FIRE   = 3'd3;

   // command directions
   localparam logic [3:0] DIR_FORWARD     = 4'd0;
   localparam logic [3:0] DIR_BACKWARD    = 4'd1;
   localparam logic [3:0] DIR_STOP        = 4'd2;
   localparam logic [3:0] DIR_TURN_LEFT   = 4'd3;
   localparam logic [3:0] DIR_TURN_RIGHT  = 4'd4;
   localparam logic [3:0] DIR_PIVOT_LEFT  = 4'd5;
   localparam logic [3:0] DIR_PIVOT_RIGHT = 4'd6;
   localparam logic [3:0] DIR_LEFT        = 4'd7;
   localparam logic [3:0] DIR_RIGHT       = 4'd8;
   localparam logic [3:0] DIR_DOWN        = 4'd9;
   localparam logic [3:0] DIR_ON          = 4'd10;
   localparam logic [3:0] DIR_OFF         = 4'd11;

   // bridge input levels
   localparam logic [1:0] BRIDGE_COAST = 2'd0;
   localparam logic [1:0] BRIDGE_FWD   = 2'd1;
   localparam logic [1:0] BRIDGE_REV   = 2'd2;

   // response status
   localparam logic [2:0] ST_APPLIED   = 3'd0;
   localparam logic [2:0] ST_BAD_DIR   = 3'd1;
   localparam logic [2:0] ST_UNKNOWN   = 3'd2;
   localparam logic [2:0] ST_DROPPED   = 3'd3;
   localparam logic [2:0] ST_NOT_CMD   = 3'd4;

   localparam int CHANNELS = 4;
   localparam int CH_LEFT   = 0;
   localparam int CH_RIGHT  = 1;
   localparam int CH_TURRET = 2;
   localparam int CH_TILT   = 3;

   typedef struct packed {
      logic [1:0]                    op;
      logic [2:0]                    target;
      logic [3:0]                    direction;
      logic signed [AMOUNT_BITS-1:0] amount;
   } req_item_type;

endpackage

### rtl/core/tdcf_if.sv
// ----------------------------------------------------------------------------
// tdcf interfaces
// Request, response and register write channels of the drive command block
// ----------------------------------------------------------------------------
interface tdcf_req_if
   import tdcf_pkg::*;
();
   logic                    valid;
   logic                    ready;
   logic [1:0]              op;
   logic [2:0]              target;
   logic [3:0]              direction;
   logic signed [AMOUNT_BITS-1:0] amount;

   modport source (output valid, output op, output target, output direction,
                   output amount, input ready);
   modport sink   (input valid, input op, input target, input direction,
                   input amount, output ready);
endinterface

interface tdcf_rsp_if #(parameter int DUTY_BITS = 8) ();
   logic                 valid;
   logic                 ready;
   logic [1:0]           left_track_dir;
   logic [DUTY_BITS-1:0] left_track_duty;
   logic [1:0]           right_track_dir;
   logic [DUTY_BITS-1:0] right_track_duty;
   logic [1:0]           turret_dir;
   logic [DUTY_BITS-1:0] turret_duty;
   logic [1:0]           tilt_dir;
   logic [DUTY_BITS-1:0] tilt_duty;
   logic                 fire_out;
   logic                 safe_flag;
   logic [2:0]           status;

   modport source (output valid, output left_track_dir, output left_track_duty,
                   output right_track_dir, output right_track_duty,
                   output turret_dir, output turret_duty, output tilt_dir,
                   output tilt_duty, output fire_out, output safe_flag,
                   output status, input ready);
   modport sink   (input valid, input left_track_dir, input left_track_duty,
                   input right_track_dir, input right_track_duty,
                   input turret_dir, input turret_duty, input tilt_dir,
                   input tilt_duty, input fire_out, input safe_flag,
                   input status, output ready);
endinterface

interface tdcf_csr_if
   import tdcf_pkg::*;
();
   logic                    valid;
   logic                    ready;
   logic [TIMEOUT_BITS-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/tracked_drive_command_failsafe.sv
// ----------------------------------------------------------------------------
// tracked_drive_command_failsafe
// Drive command decoder with H-bridge state, fire burst and failsafe watchdog
// ----------------------------------------------------------------------------
// One request can be taken in every clock cycle while responses are taken. A
// request is held in the input register, and the decode and counter update
// then write the state and the status register, from which the response is
// driven. A response that is not taken holds the input register, and once
// that is full the request channel stalls too. That single decode plus the
// watchdog compare on the millisecond count sets the clock limit. The response
// carries the outputs after the request together with its status. The
// watchdog timeout resets to 500 ms and is written through the register
// channel, which is always ready. Duty width follows DUTY_BITS.
module tracked_drive_command_failsafe
   import tdcf_pkg::*;
#(
   parameter int DUTY_BITS = 8
) (
   input  logic       clock,
   input  logic       reset,
   tdcf_req_if.sink   req_chan,
   tdcf_rsp_if.source rsp_chan,
   tdcf_csr_if.sink   csr_chan
);

   logic         item_valid;
   req_item_type item;
   logic         advance;

   tdcf_req_stage u_req_stage (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   tdcf_engine #(
      .DUTY_BITS (DUTY_BITS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .advance    (advance),
      .rsp_chan   (rsp_chan),
      .csr_chan   (csr_chan)
   );

endmodule

### rtl/core/tdcf_req_stage.sv
// ----------------------------------------------------------------------------
// tdcf_req_stage
// Input register: holds one request until the engine takes it
// ----------------------------------------------------------------------------
module tdcf_req_stage
   import tdcf_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   tdcf_req_if.sink        req_chan,
   input  logic            advance,
   output logic            item_valid,
   output req_item_type    item
);

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;
   logic         load;

   assign req_chan.ready = !valid_ff || advance;
   assign load           = req_chan.valid && req_chan.ready;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff.op        <= req_chan.op;
         item_ff.target    <= req_chan.target;
         item_ff.direction <= req_chan.direction;
         item_ff.amount    <= req_chan.amount;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

### rtl/core/tdcf_engine.sv
// ----------------------------------------------------------------------------
// tdcf_engine
// Drive state, watchdog, fire burst and response register
// ----------------------------------------------------------------------------
module tdcf_engine
   import tdcf_pkg::*;
#(
   parameter int DUTY_BITS = 8
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            item_valid,
   input  req_item_type    item,
   output logic            advance,
   tdcf_rsp_if.source      rsp_chan,
   tdcf_csr_if.sink        csr_chan
);

   localparam logic [DUTY_BITS-1:0] DUTY_MAX = '1;

   logic [1:0]              dir_ff  [CHANNELS];
   logic [1:0]              dir_in  [CHANNELS];
   logic [DUTY_BITS-1:0]    duty_ff [CHANNELS];
   logic [DUTY_BITS-1:0]    duty_in [CHANNELS];
   logic                    fire_on_ff, fire_on_in;
   logic [BURST_BITS-1:0]   fire_rem_ff, fire_rem_in;
   logic [MS_BITS-1:0]      ms_ff, ms_in;
   logic                    safe_ff, safe_in;
   logic                    hold_ff, hold_in;
   logic [TIMEOUT_BITS-1:0] timeout_ff;
   logic [2:0]              status_ff, status_in;
   logic                    rsp_valid_ff;

   logic                    take;
   logic                    ok;
   logic [DUTY_BITS-1:0]    speed;
   logic [BURST_BITS-1:0]   burst;
   logic [MS_BITS-1:0]      ms_inc;
   logic [1:0]              speed_fwd;
   logic [1:0]              speed_rev;

   function automatic logic [DUTY_BITS-1:0] clamp_speed(
      input logic signed [AMOUNT_BITS-1:0] a);
      if (a[AMOUNT_BITS-1]) begin
         return '0;
      end else if (a[AMOUNT_BITS-2:0] > (AMOUNT_BITS-1)'(DUTY_MAX)) begin
         return DUTY_MAX;
      end else begin
         return a[DUTY_BITS-1:0];
      end
   endfunction

   function automatic logic [BURST_BITS-1:0] clamp_burst(
      input logic signed [AMOUNT_BITS-1:0] a);
      if (a[AMOUNT_BITS-1]) begin
         return '0;
      end else if (|a[AMOUNT_BITS-2:BURST_BITS]) begin
         return BURST_MAX;
      end else begin
         return a[BURST_BITS-1:0];
      end
   endfunction

   assign advance = !rsp_valid_ff || rsp_chan.ready;
   assign take    = item_valid && advance;

   assign speed     = clamp_speed(item.amount);
   assign burst     = clamp_burst(item.amount);
   assign ms_inc    = (ms_ff == MS_MAX) ? ms_ff : ms_ff + 1'b1;
   assign speed_fwd = (speed == '0) ? BRIDGE_COAST : BRIDGE_FWD;
   assign speed_rev = (speed == '0) ? BRIDGE_COAST : BRIDGE_REV;

   always_comb begin
      for (int i = 0; i < CHANNELS; i++) begin
         dir_in[i]  = dir_ff[i];
         duty_in[i] = duty_ff[i];
      end
      fire_on_in  = fire_on_ff;
      fire_rem_in = fire_rem_ff;
      ms_in       = ms_ff;
      safe_in     = safe_ff;
      hold_in     = hold_ff;
      status_in   = ST_NOT_CMD;
      ok          = 1'b1;

      case (item.op)
         OP_COMMAND: begin
            if (hold_ff) begin
               status_in = ST_DROPPED;
            end else if (item.target > TGT_FIRE) begin
               status_in = ST_UNKNOWN;
            end else begin
               case (item.target)
                  TGT_TRACK: begin
                     case (item.direction)
                        DIR_FORWARD: begin
                           dir_in[CH_LEFT]  = speed_fwd; duty_in[CH_LEFT]  = speed;
                           dir_in[CH_RIGHT] = speed_fwd; duty_in[CH_RIGHT] = speed;
                        end
                        DIR_BACKWARD: begin
                           dir_in[CH_LEFT]  = speed_rev; duty_in[CH_LEFT]  = speed;
                           dir_in[CH_RIGHT] = speed_rev; duty_in[CH_RIGHT] = speed;
                        end
                        DIR_STOP: begin
                           dir_in[CH_LEFT]  = BRIDGE_COAST; duty_in[CH_LEFT]  = '0;
                           dir_in[CH_RIGHT] = BRIDGE_COAST; duty_in[CH_RIGHT] = '0;
                        end
                        DIR_TURN_LEFT: begin
                           dir_in[CH_LEFT]  = BRIDGE_COAST; duty_in[CH_LEFT]  = '0;
                           dir_in[CH_RIGHT] = speed_fwd;    duty_in[CH_RIGHT] = speed;
                        end
                        DIR_TURN_RIGHT: begin
                           dir_in[CH_LEFT]  = speed_fwd;    duty_in[CH_LEFT]  = speed;
                           dir_in[CH_RIGHT] = BRIDGE_COAST; duty_in[CH_RIGHT] = '0;
                        end
                        DIR_PIVOT_LEFT: begin
                           dir_in[CH_LEFT]  = speed_rev; duty_in[CH_LEFT]  = speed;
                           dir_in[CH_RIGHT] = speed_fwd; duty_in[CH_RIGHT] = speed;
                        end
                        DIR_PIVOT_RIGHT: begin
                           dir_in[CH_LEFT]  = speed_fwd; duty_in[CH_LEFT]  = speed;
                           dir_in[CH_RIGHT] = speed_rev; duty_in[CH_RIGHT] = speed;
                        end
                        default: begin
                           ok = 1'b0;
                        end
                     endcase
                  end
                  TGT_TURRET: begin
                     case (item.direction)
                        DIR_LEFT: begin
                           dir_in[CH_TURRET] = speed_rev; duty_in[CH_TURRET] = speed;
                        end
                        DIR_RIGHT: begin
                           dir_in[CH_TURRET] = speed_fwd; duty_in[CH_TURRET] = speed;
                        end
                        DIR_STOP: begin
                           dir_in[CH_TURRET] = BRIDGE_COAST; duty_in[CH_TURRET] = '0;
                        end
                        default: begin
                           ok = 1'b0;
                        end
                     endcase
                  end
                  TGT_TILT: begin
                     case (item.direction)
                        DIR_DOWN: begin
                           dir_in[CH_TILT] = speed_fwd; duty_in[CH_TILT] = speed;
                        end
                        DIR_STOP: begin
                           dir_in[CH_TILT] = BRIDGE_COAST; duty_in[CH_TILT] = '0;
                        end
                        default: begin
                           ok = 1'b0;
                        end
                     endcase
                  end
                  default: begin
                     case (item.direction)
                        DIR_ON: begin
                           fire_on_in  = 1'b1;
                           fire_rem_in = burst;
                        end
                        DIR_OFF: begin
                           fire_on_in  = 1'b0;
                           fire_rem_in = '0;
                        end
                        default: begin
                           ok = 1'b0;
                        end
                     endcase
                  end
               endcase
               ms_in     = '0;
               safe_in   = 1'b0;
               status_in = ok ? ST_APPLIED : ST_BAD_DIR;
            end
         end
         OP_TICK: begin
            ms_in = ms_inc;
            // watchdog expiry
            if (!safe_ff && (ms_inc > {1'b0, timeout_ff})) begin
               for (int i = 0; i < CHANNELS; i++) begin
                  dir_in[i]  = BRIDGE_COAST;
                  duty_in[i] = '0;
               end
               fire_on_in  = 1'b0;
               fire_rem_in = '0;
               safe_in     = 1'b1;
            end
            // burst countdown
            if (fire_on_in) begin
               if (fire_rem_in <= BURST_BITS'(1)) begin
                  fire_on_in  = 1'b0;
                  fire_rem_in = '0;
               end else begin
                  fire_rem_in = fire_rem_in - 1'b1;
               end
            end
         end
         OP_UPDATE_START: begin
            if (!safe_ff) begin
               for (int i = 0; i < CHANNELS; i++) begin
                  dir_in[i]  = BRIDGE_COAST;
                  duty_in[i] = '0;
               end
               fire_on_in  = 1'b0;
               fire_rem_in = '0;
            end
            safe_in = 1'b1;
            hold_in = 1'b1;
         end
         default: begin
            hold_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            dir_ff[i]  <= BRIDGE_COAST;
            duty_ff[i] <= '0;
         end
         fire_on_ff  <= 1'b0;
         fire_rem_ff <= '0;
         ms_ff       <= '0;
         safe_ff     <= 1'b1;
         hold_ff     <= 1'b0;
      end else if (take) begin
         for (int i = 0; i < CHANNELS; i++) begin
            dir_ff[i]  <= dir_in[i];
            duty_ff[i] <= duty_in[i];
         end
         fire_on_ff  <= fire_on_in;
         fire_rem_ff <= fire_rem_in;
         ms_ff       <= ms_in;
         safe_ff     <= safe_in;
         hold_ff     <= hold_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         status_ff <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_chan.valid) begin
         timeout_ff <= csr_chan.data;
      end
   end

   assign csr_chan.ready = 1'b1;

   // response fields come straight from the state, which only moves on take
   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.left_track_dir   = dir_ff[CH_LEFT];
   assign rsp_chan.left_track_duty  = duty_ff[CH_LEFT];
   assign rsp_chan.right_track_dir  = dir_ff[CH_RIGHT];
   assign rsp_chan.right_track_duty = duty_ff[CH_RIGHT];
   assign rsp_chan.turret_dir       = dir_ff[CH_TURRET];
   assign rsp_chan.turret_duty      = duty_ff[CH_TURRET];
   assign rsp_chan.tilt_dir         = dir_ff[CH_TILT];
   assign rsp_chan.tilt_duty        = duty_ff[CH_TILT];
   assign rsp_chan.fire_out         = fire_on_ff;
   assign rsp_chan.safe_flag        = safe_ff;
   assign rsp_chan.status           = status_ff;

   // state only moves when a request is taken
   a_state_held: assert property (@(posedge clock) disable iff (reset)
      !take |=> $stable(safe_ff) && $stable(hold_ff) && $stable(ms_ff)
                && $stable(fire_on_ff) && $stable(fire_rem_ff))
      else $error("drive state changed without a request");

   // safe state means everything is stopped
   a_safe_stopped: assert property (@(posedge clock) disable iff (reset)
      safe_ff |-> !fire_on_ff && (duty_ff[CH_LEFT] == '0) && (duty_ff[CH_RIGHT] == '0)
                  && (duty_ff[CH_TURRET] == '0) && (duty_ff[CH_TILT] == '0))
      else $error("safe state with an output still driven");

   // zero duty always coasts the bridge
   a_zero_coast: assert property (@(posedge clock) disable iff (reset)
      ((duty_ff[CH_LEFT] == '0) == (dir_ff[CH_LEFT] == BRIDGE_COAST))
      && ((duty_ff[CH_RIGHT] == '0) == (dir_ff[CH_RIGHT] == BRIDGE_COAST))
      && ((duty_ff[CH_TURRET] == '0) == (dir_ff[CH_TURRET] == BRIDGE_COAST))
      && ((duty_ff[CH_TILT] == '0) == (dir_ff[CH_TILT] == BRIDGE_COAST)))
      else $error("bridge direction does not match duty");

   // commands during an update change nothing
   a_hold_drops: assert property (@(posedge clock) disable iff (reset)
      take && hold_ff && (item.op == OP_COMMAND)
      |=> $stable(ms_ff) && $stable(safe_ff) && $stable(fire_on_ff)
          && (status_ff == ST_DROPPED))
      else $error("command acted on during update hold");

endmodule

### tb/sv/tracked_drive_command_failsafe_tb.sv
// ----------------------------------------------------------------------------
// tracked_drive_command_failsafe_tb
// Directed and random drive commands, millisecond ticks and update requests
// go in through a sender that works in bursts. The receiver stalls on a
// pattern that keeps changing. A model of the channel, fire and watchdog
// state predicts every response, and each response is checked field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tracked_drive_command_failsafe_tb;
   import tdcf_pkg::*;

   localparam int DUTY_BITS      = 8;
   localparam int DUTY_LIMIT     = (1 << DUTY_BITS) - 1;
   localparam int SETTLE_CYCLES  = 4;
   localparam int WATCHDOG_LIMIT = 1000;

   typedef struct packed {
      logic [1:0]           left_dir;
      logic [DUTY_BITS-1:0] left_duty;
      logic [1:0]           right_dir;
      logic [DUTY_BITS-1:0] right_duty;
      logic [1:0]           turret_dir;
      logic [DUTY_BITS-1:0] turret_duty;
      logic [1:0]           tilt_dir;
      logic [DUTY_BITS-1:0] tilt_duty;
      logic                 fire;
      logic                 safe;
      logic [2:0]           status;
   } drive_outputs_type;

   logic clock;
   logic reset;

   tdcf_req_if                             req_if ();
   tdcf_rsp_if #(.DUTY_BITS(DUTY_BITS))    rsp_if ();
   tdcf_csr_if                             csr_if ();

   tracked_drive_command_failsafe #(
      .DUTY_BITS(DUTY_BITS)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   req_item_type      queued_requests[$];
   drive_outputs_type expected_outputs[$];
   int                error_count;
   int                idle_cycles;
   logic              req_accepted;
   int                send_run_left;
   int                send_gap_left;
   logic [15:0]       stall_pattern;
   logic [6:0]        stall_step;

   // predicted block state
   logic [1:0]              chan_dir [CHANNELS];
   logic [DUTY_BITS-1:0]    chan_duty [CHANNELS];
   logic                    fire_on;
   logic [BURST_BITS-1:0]   fire_ms_left;
   logic [MS_BITS-1:0]      ms_idle;
   logic                    safe_state;
   logic                    update_hold;
   logic [TIMEOUT_BITS-1:0] timeout_ms;

   function automatic int clamp_amount(input int amt, input int hi);
      if (amt < 0) return 0;
      return (amt > hi) ? hi : amt;
   endfunction

   function automatic void set_channel(input int ch, input logic fwd,
                                       input logic [DUTY_BITS-1:0] duty);
      chan_duty[ch] = duty;
      chan_dir[ch]  = (duty == 0) ? BRIDGE_COAST : (fwd ? BRIDGE_FWD : BRIDGE_REV);
   endfunction

   function automatic void enter_safe_state();
      if (safe_state) return;
      safe_state = 1'b1;
      for (int i = 0; i < CHANNELS; i++) set_channel(i, 1'b1, '0);
      fire_on      = 1'b0;
      fire_ms_left = '0;
   endfunction

   function automatic logic [2:0] apply_command(input req_item_type r);
      logic [DUTY_BITS-1:0] speed;
      logic                 ok;
      speed = DUTY_BITS'(clamp_amount(r.amount, DUTY_LIMIT));
      if (r.target > TGT_FIRE) return ST_UNKNOWN;
      ok = 1'b1;
      case (r.target)
         TGT_TRACK: begin
            case (r.direction)
               DIR_FORWARD: begin
                  set_channel(CH_LEFT, 1'b1, speed);
                  set_channel(CH_RIGHT, 1'b1, speed);
               end
               DIR_BACKWARD: begin
                  set_channel(CH_LEFT, 1'b0, speed);
                  set_channel(CH_RIGHT, 1'b0, speed);
               end
               DIR_STOP: begin
                  set_channel(CH_LEFT, 1'b1, '0);
                  set_channel(CH_RIGHT, 1'b1, '0);
               end
               DIR_TURN_LEFT: begin
                  set_channel(CH_LEFT, 1'b1, '0);
                  set_channel(CH_RIGHT, 1'b1, speed);
               end
               DIR_TURN_RIGHT: begin
                  set_channel(CH_LEFT, 1'b1, speed);
                  set_channel(CH_RIGHT, 1'b1, '0);
               end
               DIR_PIVOT_LEFT: begin
                  set_channel(CH_LEFT, 1'b0, speed);
                  set_channel(CH_RIGHT, 1'b1, speed);
               end
               DIR_PIVOT_RIGHT: begin
                  set_channel(CH_LEFT, 1'b1, speed);
                  set_channel(CH_RIGHT, 1'b0, speed);
               end
               default: ok = 1'b0;
            endcase
         end
         TGT_TURRET: begin
            case (r.direction)
               DIR_LEFT:  set_channel(CH_TURRET, 1'b0, speed);
               DIR_RIGHT: set_channel(CH_TURRET, 1'b1, speed);
               DIR_STOP:  set_channel(CH_TURRET, 1'b1, '0);
               default:   ok = 1'b0;
            endcase
         end
         TGT_TILT: begin
            case (r.direction)
               DIR_DOWN: set_channel(CH_TILT, 1'b1, speed);
               DIR_STOP: set_channel(CH_TILT, 1'b1, '0);
               default:  ok = 1'b0;
            endcase
         end
         default: begin
            case (r.direction)
               DIR_ON: begin
                  fire_on      = 1'b1;
                  fire_ms_left = BURST_BITS'(clamp_amount(r.amount, int'(BURST_MAX)));
               end
               DIR_OFF: begin
                  fire_on      = 1'b0;
                  fire_ms_left = '0;
               end
               default: ok = 1'b0;
            endcase
         end
      endcase
      // even a bad direction refreshes the watchdog
      ms_idle    = '0;
      safe_state = 1'b0;
      return ok ? ST_APPLIED : ST_BAD_DIR;
   endfunction

   function automatic void count_millisecond();
      if (ms_idle != MS_MAX) ms_idle = ms_idle + 1'b1;
      if (!safe_state && ms_idle > MS_BITS'(timeout_ms)) enter_safe_state();
      if (fire_on) begin
         if (fire_ms_left <= 1) begin
            fire_on      = 1'b0;
            fire_ms_left = '0;
         end else begin
            fire_ms_left = fire_ms_left - 1'b1;
         end
      end
   endfunction

   function automatic drive_outputs_type apply_request(input req_item_type r);
      drive_outputs_type o;
      logic [2:0]        st;
      st = ST_NOT_CMD;
      case (r.op)
         OP_COMMAND: st = update_hold ? ST_DROPPED : apply_command(r);
         OP_TICK:    count_millisecond();
         OP_UPDATE_START: begin
            enter_safe_state();
            update_hold = 1'b1;
         end
         default: update_hold = 1'b0;
      endcase
      o.left_dir    = chan_dir[CH_LEFT];
      o.left_duty   = chan_duty[CH_LEFT];
      o.right_dir   = chan_dir[CH_RIGHT];
      o.right_duty  = chan_duty[CH_RIGHT];
      o.turret_dir  = chan_dir[CH_TURRET];
      o.turret_duty = chan_duty[CH_TURRET];
      o.tilt_dir    = chan_dir[CH_TILT];
      o.tilt_duty   = chan_duty[CH_TILT];
      o.fire        = fire_on;
      o.safe        = safe_state;
      o.status      = st;
      return o;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s expected %0d got %0d", name, want, got);
         error_count++;
      end
   endfunction

   function automatic int random_amount();
      case ($urandom_range(0, 5))
         0:       return $urandom_range(0, 255);
         1:       return $urandom_range(256, 70000);
         2:       return $urandom;
         3:       return 0;
         4:       return DUTY_LIMIT;
         default: return $urandom_range(1, 20);
      endcase
   endfunction

   // mostly well-formed commands and ticks, a few update windows, some noise
   function automatic req_item_type random_request(input int tick_pct);
      req_item_type r;
      int           roll;
      roll        = $urandom_range(0, 99);
      r.op        = OP_COMMAND;
      r.target    = TGT_TRACK;
      r.direction = DIR_STOP;
      r.amount    = random_amount();
      if (roll < tick_pct) begin
         r.op = OP_TICK;
      end else if (roll < tick_pct + 3) begin
         r.op = OP_UPDATE_START;
      end else if (roll < tick_pct + 8) begin
         r.op = OP_UPDATE_END;
      end else if (roll < 90) begin
         r.target = 3'($urandom_range(0, 3));
         case (r.target)
            TGT_TRACK: r.direction = 4'($urandom_range(0, 6));
            TGT_TURRET: begin
               case ($urandom_range(0, 2))
                  0:       r.direction = DIR_LEFT;
                  1:       r.direction = DIR_RIGHT;
                  default: r.direction = DIR_STOP;
               endcase
            end
            TGT_TILT: r.direction = ($urandom_range(0, 1) == 0) ? DIR_DOWN : DIR_STOP;
            default: begin
               r.direction = ($urandom_range(0, 3) == 0) ? DIR_OFF : DIR_ON;
               if ($urandom_range(0, 3) != 0) r.amount = $urandom_range(0, 12);
            end
         endcase
      end else begin
         r.op        = 2'($urandom);
         r.target    = 3'($urandom);
         r.direction = 4'($urandom);
         r.amount    = $urandom;
      end
      return r;
   endfunction

   task automatic queue_request(input logic [1:0] op, input logic [2:0] tgt,
                                input logic [3:0] dir, input int amt);
      req_item_type r;
      r.op        = op;
      r.target    = tgt;
      r.direction = dir;
      r.amount    = amt;
      queued_requests.push_back(r);
   endtask

   task automatic write_timeout(input logic [TIMEOUT_BITS-1:0] value);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.data  <= value;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      while (queued_requests.size() != 0 || req_if.valid || expected_outputs.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic run_random_phase(input logic [TIMEOUT_BITS-1:0] timeout, input int count,
                                   input int tick_pct);
      write_timeout(timeout);
      for (int n = 0; n < count; n++) queued_requests.push_back(random_request(tick_pct));
      wait_for_drain();
   endtask

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // request driver
   always @(negedge clock) begin
      req_item_type r;
      logic         next_valid;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_accepted) begin
         next_valid = 1'b0;
         if (send_gap_left > 0) begin
            send_gap_left--;
         end else if (queued_requests.size() > 0) begin
            r = queued_requests.pop_front();
            req_if.op        <= r.op;
            req_if.target    <= r.target;
            req_if.direction <= r.direction;
            req_if.amount    <= r.amount;
            next_valid = 1'b1;
            if (send_run_left <= 1) begin
               send_run_left = $urandom_range(1, 40);
               send_gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               send_run_left--;
            end
         end
         req_if.valid <= next_valid;
      end
   end

   // response stalls
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (stall_step == 0) begin
            case ($urandom_range(0, 2))
               0:       stall_pattern = '1;
               1:       stall_pattern = 16'($urandom) | 16'h1;
               default: stall_pattern = (16'($urandom) & 16'($urandom)) | 16'h1;
            endcase
         end
         rsp_if.ready <= stall_pattern[stall_step[3:0]];
         stall_step = stall_step + 1'b1;
      end
   end

   // monitor, prediction and watchdog
   always @(posedge clock) begin
      drive_outputs_type want;
      drive_outputs_type got;
      if (reset) begin
         req_accepted <= 1'b0;
         idle_cycles  <= 0;
         for (int i = 0; i < CHANNELS; i++) begin
            chan_dir[i]  = BRIDGE_COAST;
            chan_duty[i] = '0;
         end
         fire_on      = 1'b0;
         fire_ms_left = '0;
         ms_idle      = '0;
         safe_state   = 1'b1;
         update_hold  = 1'b0;
         timeout_ms   = TIMEOUT_RESET;
      end else begin
         req_accepted <= req_if.valid && req_if.ready;
         if (rsp_if.valid && rsp_if.ready) begin
            got = {rsp_if.left_track_dir, rsp_if.left_track_duty,
                   rsp_if.right_track_dir, rsp_if.right_track_duty,
                   rsp_if.turret_dir, rsp_if.turret_duty,
                   rsp_if.tilt_dir, rsp_if.tilt_duty,
                   rsp_if.fire_out, rsp_if.safe_flag, rsp_if.status};
            if (expected_outputs.size() == 0) begin
               $error("response with no request outstanding");
               error_count++;
            end else begin
               want = expected_outputs.pop_front();
               check_field("left_track_dir", 32'(want.left_dir), 32'(got.left_dir));
               check_field("left_track_duty", 32'(want.left_duty), 32'(got.left_duty));
               check_field("right_track_dir", 32'(want.right_dir), 32'(got.right_dir));
               check_field("right_track_duty", 32'(want.right_duty),
                           32'(got.right_duty));
               check_field("turret_dir", 32'(want.turret_dir), 32'(got.turret_dir));
               check_field("turret_duty", 32'(want.turret_duty), 32'(got.turret_duty));
               check_field("tilt_dir", 32'(want.tilt_dir), 32'(got.tilt_dir));
               check_field("tilt_duty", 32'(want.tilt_duty), 32'(got.tilt_duty));
               check_field("fire_out", 32'(want.fire), 32'(got.fire));
               check_field("safe_flag", 32'(want.safe), 32'(got.safe));
               check_field("status", 32'(want.status), 32'(got.status));
            end
         end
         if (csr_if.valid && csr_if.ready) timeout_ms = csr_if.data;
         if (req_if.valid && req_if.ready) begin
            expected_outputs.push_back(apply_request({req_if.op, req_if.target,
                                                      req_if.direction, req_if.amount}));
         end
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
             (csr_if.valid && csr_if.ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tracked_drive_command_failsafe_tb NOT OK");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin
      error_count      = 0;
      send_run_left    = 0;
      send_gap_left    = 0;
      stall_pattern    = '1;
      stall_step       = '0;
      req_if.valid     = 1'b0;
      req_if.op        = OP_TICK;
      req_if.target    = TGT_TRACK;
      req_if.direction = DIR_STOP;
      req_if.amount    = 0;
      rsp_if.ready     = 1'b0;
      csr_if.valid     = 1'b0;
      csr_if.data      = TIMEOUT_RESET;
      reset            = 1'b1;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // directed requests under the reset timeout
      queue_request(OP_TICK, TGT_TRACK, DIR_STOP, 0);
      queue_request(OP_COMMAND, TGT_TRACK, DIR_FORWARD, 255);
      queue_request(OP_COMMAND, TGT_TRACK, DIR_BACKWARD, 256);
      queue_request(OP_COMMAND, TGT_TRACK, DIR_TURN_LEFT, 100);
      queue_request(OP_COMMAND, TGT_TRACK, DIR_TURN_RIGHT, 32'h7FFF_FFFF);
      queue_request(OP_COMMAND, TGT_TRACK, DIR_PIVOT_LEFT, 1);
      queue_request(OP_COMMAND, TGT_TRACK, DIR_PIVOT_RIGHT, -1);
      queue_request(OP_COMMAND, TGT_TRACK, DIR_STOP, 50);
      queue_request(OP_COMMAND, TGT_TURRET, DIR_LEFT, 32'h8000_0000);
      queue_request(OP_COMMAND, TGT_TURRET, DIR_RIGHT, 200);
      queue_request(OP_COMMAND, TGT_TILT, DIR_DOWN, 128);
      queue_request(OP_COMMAND, TGT_TURRET, DIR_DOWN, 10);
      queue_request(OP_COMMAND, TGT_TILT, DIR_STOP, 10);
      queue_request(OP_COMMAND, TGT_FIRE, DIR_ON, 0);
      queue_request(OP_TICK, TGT_TRACK, DIR_STOP, 0);
      queue_request(OP_COMMAND, TGT_FIRE, DIR_ON, 3);
      queue_request(OP_TICK, TGT_TRACK, DIR_STOP, 0);
      queue_request(OP_COMMAND, TGT_FIRE, DIR_OFF, 3);
      queue_request(OP_COMMAND, TGT_FIRE, DIR_ON, 40000);
      queue_request(OP_COMMAND, TGT_TRACK, 4'hF, -1);
      queue_request(OP_COMMAND, 3'd7, 4'hF, 20);
      queue_request(OP_COMMAND, 3'd4, DIR_FORWARD, 20);
      queue_request(OP_UPDATE_START, TGT_TRACK, DIR_STOP, 0);
      queue_request(OP_COMMAND, TGT_TRACK, DIR_FORWARD, 10);
      queue_request(OP_TICK, TGT_TRACK, DIR_STOP, 0);
      queue_request(OP_UPDATE_END, TGT_TRACK, DIR_STOP, 0);
      queue_request(OP_COMMAND, TGT_FIRE, 4'd12, 5);
      wait_for_drain();

      run_random_phase(16'd0, 50, 40);
      run_random_phase(16'd1, 60, 40);
      run_random_phase(16'($urandom_range(2, 12)), 80, 40);
      run_random_phase(16'hFFFF, 60, 35);
      run_random_phase(16'($urandom_range(20, 80)), 100, 75);
      run_random_phase(TIMEOUT_RESET, 50, 40);

      // longest timeout and longest burst counting down
      write_timeout(16'hFFFF);
      queue_request(OP_COMMAND, TGT_TRACK, DIR_FORWARD, 255);
      queue_request(OP_COMMAND, TGT_FIRE, DIR_ON, 32767);
      for (int n = 0; n < 20; n++) queue_request(OP_TICK, TGT_TRACK, DIR_STOP, 0);
      queue_request(OP_COMMAND, TGT_FIRE, DIR_OFF, 0);
      wait_for_drain();

      if (error_count == 0 && expected_outputs.size() == 0) begin
         $display("tracked_drive_command_failsafe_tb OK");
      end else begin
         $display("tracked_drive_command_failsafe_tb NOT OK");
      end
      $finish;
   end

endmodule
